/* design/copg_pkg.sv */
// Shared types and constants for the callout outline path generator.
package copg_pkg;

    localparam int COORD_BITS_DEF = 24;

    localparam int FW  = 24;    // coordinate field width
    localparam int SZW = 23;    // size field width
    localparam int HW  = 22;    // half-size width
    localparam int LW  = 25;    // local target (target minus center)
    localparam int DW  = 25;    // edge distance magnitude
    localparam int VW  = 26;    // local target plus or minus half pointer base
    localparam int AW  = 23;    // clamped offset along an edge
    localparam int WW  = 27;    // working width for signed geometry sums

    localparam int STEPS = 13;  // commands per callout
    localparam int CW    = 4;   // step counter width

    typedef enum logic [1:0] {
        CMD_MOVE  = 2'd0,
        CMD_LINE  = 2'd1,
        CMD_QUAD  = 2'd2,
        CMD_CLOSE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        EDGE_BOTTOM = 2'd0,
        EDGE_TOP    = 2'd1,
        EDGE_LEFT   = 2'd2,
        EDGE_RIGHT  = 2'd3
    } t_edge;

    typedef struct packed {
        logic signed [FW-1:0]  center_x;
        logic signed [FW-1:0]  center_y;
        logic        [SZW-1:0] rect_width;
        logic        [SZW-1:0] rect_height;
        logic        [SZW-1:0] radius_req;
        logic        [SZW-1:0] ptr_base_w;
        logic signed [FW-1:0]  target_x;
        logic signed [FW-1:0]  target_y;
    } t_in_item;

    typedef struct packed {
        logic        [1:0]    command;
        logic signed [FW-1:0] end_x;
        logic signed [FW-1:0] end_y;
        logic signed [FW-1:0] ctrl_x;
        logic signed [FW-1:0] ctrl_y;
        logic                 last;
    } t_out_item;

endpackage

/* design/callout_outline_path_generator.sv */
// Callout outline path generator: four-stage geometry pipeline, command sequencer, output register.
//
// Each accepted callout produces exactly 13 path commands (move, lines, quadratic corners, three
// pointer vertices: two base ends on the edge nearest the target and the tip, close), one command
// per cycle on the result channel while the receiver is ready; the single result port sets the
// sustained callout rate. Four register stages (input, half-sizes and local target, distances and
// limits, edge pick and pointer clamps) feed a sequencer hold that walks the 13 steps, then the
// output register; on an empty pipeline a callout passes through all of them in that order. New
// callouts keep entering the stages while the sequencer is still emitting; the output register
// holds a command until it is taken, and the sequencer steps only when that register is empty or read.
// Coordinates saturate to the signed COORD_BITS range before truncation to the 24-bit fields.
module callout_outline_path_generator #(
    parameter int COORD_BITS = copg_pkg::COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  copg_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output copg_pkg::t_out_item o_data
);
    import copg_pkg::*;

    localparam int SW = (COORD_BITS + 1 > WW) ? COORD_BITS + 1 : WW;
    localparam logic signed [SW-1:0] SAT_HI = SW'((65'sd1 <<< (COORD_BITS - 1)) - 65'sd1);
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
    localparam logic [CW-1:0]        LAST_STEP = CW'(STEPS - 1);

    function automatic logic [FW-1:0] sat_c(input logic signed [WW-1:0] v);
        logic signed [SW-1:0] e;
        e = SW'(v);
        if (e > SAT_HI) begin
            e = SAT_HI;
        end else if (e < SAT_LO) begin
            e = SAT_LO;
        end
        return e[FW-1:0];
    endfunction

    function automatic logic [DW-1:0] abs_d(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] m;
        m = (v < 0) ? -v : v;
        return m[DW-1:0];
    endfunction

    function automatic logic signed [AW-1:0] clamp_l(input logic signed [WW-1:0] v,
                                                     input logic [HW-1:0] lim);
        logic signed [WW-1:0] l;
        logic signed [WW-1:0] c;
        l = WW'($signed({1'b0, lim}));
        if (v < -l) begin
            c = -l;
        end else if (v > l) begin
            c = l;
        end else begin
            c = v;
        end
        return c[AW-1:0];
    endfunction

    // stage 1: input register
    logic     r1_v;
    t_in_item r1_in;

    // stage 2: half-sizes, radius limit, local target
    logic                 r2_v;
    logic signed [FW-1:0] r2_cx, r2_cy;
    logic        [HW-1:0] r2_w, r2_h, r2_r, r2_half;
    logic signed [LW-1:0] r2_lx, r2_ly;
    logic        [HW-1:0] n2_r0, n2_r;

    // stage 3: edge distances, corner limits, pointer base ends
    logic                 r3_v;
    logic signed [FW-1:0] r3_cx, r3_cy;
    logic        [HW-1:0] r3_w, r3_h, r3_wr, r3_hr;
    logic signed [LW-1:0] r3_lx, r3_ly;
    logic        [DW-1:0] r3_db, r3_dt, r3_dl, r3_dr;
    logic signed [VW-1:0] r3_lxm, r3_lxp, r3_lym, r3_lyp;

    // stage 4: edge pick, clamped pointer offsets in emission order
    logic                 r4_v;
    logic signed [FW-1:0] r4_cx, r4_cy;
    logic        [HW-1:0] r4_w, r4_h, r4_wr, r4_hr;
    logic signed [LW-1:0] r4_lx, r4_ly;
    t_edge                r4_edge;
    logic signed [AW-1:0] r4_pf, r4_pt;
    t_edge                n4_edge;
    logic        [DW-1:0] n4_best;
    logic signed [AW-1:0] n4_ah, n4_bh, n4_av, n4_bv;
    logic signed [AW-1:0] n4_pf, n4_pt;

    // sequencer hold
    logic                 r5_v;
    logic        [CW-1:0] r_cnt;
    logic signed [FW-1:0] r5_cx, r5_cy;
    logic        [HW-1:0] r5_w, r5_h, r5_wr, r5_hr;
    logic signed [LW-1:0] r5_lx, r5_ly;
    t_edge                r5_edge;
    logic signed [AW-1:0] r5_pf, r5_pt;

    // output register
    logic      r_ov;
    t_out_item r_out;

    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic out_load, step;

    assign out_load = !r_ov || i_ready;
    assign step     = r5_v && out_load;
    assign rdy5     = !r5_v || (step && r_cnt == LAST_STEP);
    assign rdy4     = !r4_v || rdy5;
    assign rdy3     = !r3_v || rdy4;
    assign rdy2     = !r2_v || rdy3;
    assign rdy1     = !r1_v || rdy2;
    assign o_ready  = rdy1;

    // stage 2 logic
    always_comb begin
        n2_r0 = ({1'b0, r1_in.rect_width[SZW-1:1]} < r1_in.radius_req)
                ? r1_in.rect_width[SZW-1:1] : r1_in.radius_req[HW-1:0];
        n2_r  = (r1_in.rect_height[SZW-1:1] < n2_r0) ? r1_in.rect_height[SZW-1:1] : n2_r0;
    end

    // stage 4 logic: strict less-than in the order bottom, top, left, right
    always_comb begin
        n4_edge = EDGE_BOTTOM;
        n4_best = r3_db;
        if (r3_dt < n4_best) begin
            n4_edge = EDGE_TOP;
            n4_best = r3_dt;
        end
        if (r3_dl < n4_best) begin
            n4_edge = EDGE_LEFT;
            n4_best = r3_dl;
        end
        if (r3_dr < n4_best) begin
            n4_edge = EDGE_RIGHT;
        end
        n4_ah = clamp_l(WW'(r3_lxm), r3_wr);
        n4_bh = clamp_l(WW'(r3_lxp), r3_wr);
        n4_av = clamp_l(WW'(r3_lym), r3_hr);
        n4_bv = clamp_l(WW'(r3_lyp), r3_hr);
        case (n4_edge)
            EDGE_TOP: begin
                n4_pf = n4_ah;
                n4_pt = n4_bh;
            end
            EDGE_RIGHT: begin
                n4_pf = n4_bv;
                n4_pt = n4_av;
            end
            EDGE_BOTTOM: begin
                n4_pf = n4_bh;
                n4_pt = n4_ah;
            end
            default: begin
                n4_pf = n4_av;
                n4_pt = n4_bv;
            end
        endcase
    end

    // sequencer step decode
    logic        [CW-1:0] s_slot, s_bidx, s_pj;
    logic                 s_ptr, s_zero, s_ctrl, s_last;
    t_cmd                 s_cmd;
    logic signed [WW-1:0] s_w, s_h, s_wr, s_hr, s_along;
    logic signed [WW-1:0] s_ox, s_oy, s_qx, s_qy;
    t_out_item            n_out;

    always_comb begin
        s_w  = WW'($signed({1'b0, r5_w}));
        s_h  = WW'($signed({1'b0, r5_h}));
        s_wr = WW'($signed({1'b0, r5_wr}));
        s_hr = WW'($signed({1'b0, r5_hr}));
        case (r5_edge)
            EDGE_TOP:    s_slot = CW'(0);
            EDGE_RIGHT:  s_slot = CW'(2);
            EDGE_BOTTOM: s_slot = CW'(4);
            default:     s_slot = CW'(6);
        endcase
        s_ptr  = 1'b0;
        s_pj   = '0;
        s_bidx = r_cnt;
        if (r_cnt > s_slot && r_cnt <= s_slot + CW'(3)) begin
            s_ptr = 1'b1;
            s_pj  = r_cnt - s_slot - CW'(1);
        end else if (r_cnt > s_slot) begin
            s_bidx = r_cnt - CW'(3);
        end
        s_cmd   = CMD_LINE;
        s_zero  = 1'b0;
        s_ctrl  = 1'b0;
        s_last  = 1'b0;
        s_ox    = '0;
        s_oy    = '0;
        s_qx    = '0;
        s_qy    = '0;
        s_along = (s_pj == CW'(0)) ? WW'(r5_pf) : WW'(r5_pt);
        if (s_ptr) begin
            if (s_pj == CW'(1)) begin
                // pointer tip: center plus local target is the target itself
                s_ox = WW'(r5_lx);
                s_oy = WW'(r5_ly);
            end else begin
                case (r5_edge)
                    EDGE_TOP: begin
                        s_ox = s_along;
                        s_oy = s_h;
                    end
                    EDGE_BOTTOM: begin
                        s_ox = s_along;
                        s_oy = -s_h;
                    end
                    EDGE_RIGHT: begin
                        s_ox = s_w;
                        s_oy = s_along;
                    end
                    default: begin
                        s_ox = -s_w;
                        s_oy = s_along;
                    end
                endcase
            end
        end else begin
            case (s_bidx)
                CW'(0): begin
                    s_cmd = CMD_MOVE;
                    s_ox  = -s_wr;
                    s_oy  = s_h;
                end
                CW'(1): begin
                    s_ox = s_wr;
                    s_oy = s_h;
                end
                CW'(2): begin
                    s_cmd  = CMD_QUAD;
                    s_ctrl = 1'b1;
                    s_ox   = s_w;
                    s_oy   = s_hr;
                    s_qx   = s_w;
                    s_qy   = s_h;
                end
                CW'(3): begin
                    s_ox = s_w;
                    s_oy = -s_hr;
                end
                CW'(4): begin
                    s_cmd  = CMD_QUAD;
                    s_ctrl = 1'b1;
                    s_ox   = s_wr;
                    s_oy   = -s_h;
                    s_qx   = s_w;
                    s_qy   = -s_h;
                end
                CW'(5): begin
                    s_ox = -s_wr;
                    s_oy = -s_h;
                end
                CW'(6): begin
                    s_cmd  = CMD_QUAD;
                    s_ctrl = 1'b1;
                    s_ox   = -s_w;
                    s_oy   = -s_hr;
                    s_qx   = -s_w;
                    s_qy   = -s_h;
                end
                CW'(7): begin
                    s_ox = -s_w;
                    s_oy = s_hr;
                end
                CW'(8): begin
                    s_cmd  = CMD_QUAD;
                    s_ctrl = 1'b1;
                    s_ox   = -s_wr;
                    s_oy   = s_h;
                    s_qx   = -s_w;
                    s_qy   = s_h;
                end
                default: begin
                    s_cmd  = CMD_CLOSE;
                    s_zero = 1'b1;
                    s_last = 1'b1;
                end
            endcase
        end
        n_out.command = s_cmd;
        n_out.end_x   = s_zero ? '0 : sat_c(WW'(r5_cx) + s_ox);
        n_out.end_y   = s_zero ? '0 : sat_c(WW'(r5_cy) + s_oy);
        n_out.ctrl_x  = s_ctrl ? sat_c(WW'(r5_cx) + s_qx) : '0;
        n_out.ctrl_y  = s_ctrl ? sat_c(WW'(r5_cy) + s_qy) : '0;
        n_out.last    = s_last;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
            if (rdy4) r4_v <= r3_v;
            if (rdy5) begin
                r5_v  <= r4_v;
                r_cnt <= '0;
            end else if (step) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (out_load) r_ov <= r5_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r1_in <= i_data;
        end
        if (rdy2 && r1_v) begin
            r2_cx   <= r1_in.center_x;
            r2_cy   <= r1_in.center_y;
            r2_w    <= r1_in.rect_width[SZW-1:1];
            r2_h    <= r1_in.rect_height[SZW-1:1];
            r2_r    <= n2_r;
            r2_half <= r1_in.ptr_base_w[SZW-1:1];
            r2_lx   <= LW'(r1_in.target_x) - LW'(r1_in.center_x);
            r2_ly   <= LW'(r1_in.target_y) - LW'(r1_in.center_y);
        end
        if (rdy3 && r2_v) begin
            r3_cx  <= r2_cx;
            r3_cy  <= r2_cy;
            r3_w   <= r2_w;
            r3_h   <= r2_h;
            r3_wr  <= r2_w - r2_r;
            r3_hr  <= r2_h - r2_r;
            r3_lx  <= r2_lx;
            r3_ly  <= r2_ly;
            r3_db  <= abs_d(WW'(r2_ly) + WW'($signed({1'b0, r2_h})));
            r3_dt  <= abs_d(WW'(r2_ly) - WW'($signed({1'b0, r2_h})));
            r3_dl  <= abs_d(WW'(r2_lx) + WW'($signed({1'b0, r2_w})));
            r3_dr  <= abs_d(WW'(r2_lx) - WW'($signed({1'b0, r2_w})));
            r3_lxm <= VW'(r2_lx) - VW'($signed({1'b0, r2_half}));
            r3_lxp <= VW'(r2_lx) + VW'($signed({1'b0, r2_half}));
            r3_lym <= VW'(r2_ly) - VW'($signed({1'b0, r2_half}));
            r3_lyp <= VW'(r2_ly) + VW'($signed({1'b0, r2_half}));
        end
        if (rdy4 && r3_v) begin
            r4_cx   <= r3_cx;
            r4_cy   <= r3_cy;
            r4_w    <= r3_w;
            r4_h    <= r3_h;
            r4_wr   <= r3_wr;
            r4_hr   <= r3_hr;
            r4_lx   <= r3_lx;
            r4_ly   <= r3_ly;
            r4_edge <= n4_edge;
            r4_pf   <= n4_pf;
            r4_pt   <= n4_pt;
        end
        if (rdy5 && r4_v) begin
            r5_cx   <= r4_cx;
            r5_cy   <= r4_cy;
            r5_w    <= r4_w;
            r5_h    <= r4_h;
            r5_wr   <= r4_wr;
            r5_hr   <= r4_hr;
            r5_lx   <= r4_lx;
            r5_ly   <= r4_ly;
            r5_edge <= r4_edge;
            r5_pf   <= r4_pf;
            r5_pt   <= r4_pt;
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_v |-> r_cnt <= LAST_STEP)
        else $error("step counter past last command");

    a_last_is_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last == (o_data.command == CMD_CLOSE)))
        else $error("last flag and close command disagree");

    a_run_starts_with_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_data.last |=> !o_valid || o_data.command == CMD_MOVE)
        else $error("run after close does not begin with move");

    a_empty_front_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r1_v |-> o_ready)
        else $error("empty input stage refuses a transaction");

endmodule

/* tb/callout_path_checker.sv */
// Outline checker: predicts each callout's path commands and compares them with the block's output.
`timescale 1ns / 100ps

module callout_path_checker #(
    parameter int COORD_BITS = copg_pkg::COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  copg_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  copg_pkg::t_out_item i_out_data,
    output int                  o_mismatches,
    output int                  o_pending
);
    import copg_pkg::*;

    t_out_item expected_path[$];
    t_out_item head_cmd;

    // saturate to the signed coordinate range, then keep the field bits
    function automatic logic [FW-1:0] clip_coord(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            v = hi;
        end else if (v < lo) begin
            v = lo;
        end
        return v[FW-1:0];
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp_span(input longint v, input longint lim);
        if (v < -lim) return -lim;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic void push_cmd(input t_cmd cmd, input longint ex, input longint ey,
                                     input longint qx, input longint qy, input logic fin);
        t_out_item o;
        o.command = cmd;
        o.end_x   = clip_coord(ex);
        o.end_y   = clip_coord(ey);
        o.ctrl_x  = clip_coord(qx);
        o.ctrl_y  = clip_coord(qy);
        o.last    = fin;
        expected_path.insert(expected_path.size(), o);
    endfunction

    // clockwise outline: top edge left to right, right edge down, bottom edge back, left edge up
    function automatic void predict_outline(input t_in_item it);
        longint cx, cy, w, h, r, half, tx, ty, lx, ly, best, d, base_neg, base_pos;
        t_edge  side;
        cx   = $signed(it.center_x);
        cy   = $signed(it.center_y);
        w    = it.rect_width >> 1;
        h    = it.rect_height >> 1;
        r    = it.radius_req;
        half = it.ptr_base_w >> 1;
        tx   = $signed(it.target_x);
        ty   = $signed(it.target_y);
        lx   = tx - cx;
        ly   = ty - cy;
        if (w < r) r = w;
        if (h < r) r = h;

        // strict less-than: earlier edge keeps a tie
        side = EDGE_BOTTOM;
        best = mag(ly + h);
        d = mag(ly - h);
        if (d < best) begin
            best = d;
            side = EDGE_TOP;
        end
        d = mag(lx + w);
        if (d < best) begin
            best = d;
            side = EDGE_LEFT;
        end
        d = mag(lx - w);
        if (d < best) begin
            best = d;
            side = EDGE_RIGHT;
        end

        if (side == EDGE_TOP || side == EDGE_BOTTOM) begin
            base_neg = clamp_span(lx - half, w - r);
            base_pos = clamp_span(lx + half, w - r);
        end else begin
            base_neg = clamp_span(ly - half, h - r);
            base_pos = clamp_span(ly + half, h - r);
        end

        push_cmd(CMD_MOVE, cx - w + r, cy + h, 0, 0, 1'b0);
        if (side == EDGE_TOP) begin
            push_cmd(CMD_LINE, cx + base_neg, cy + h, 0, 0, 1'b0);
            push_cmd(CMD_LINE, tx, ty, 0, 0, 1'b0);
            push_cmd(CMD_LINE, cx + base_pos, cy + h, 0, 0, 1'b0);
        end
        push_cmd(CMD_LINE, cx + w - r, cy + h, 0, 0, 1'b0);
        push_cmd(CMD_QUAD, cx + w, cy + h - r, cx + w, cy + h, 1'b0);
        if (side == EDGE_RIGHT) begin
            push_cmd(CMD_LINE, cx + w, cy + base_pos, 0, 0, 1'b0);
            push_cmd(CMD_LINE, tx, ty, 0, 0, 1'b0);
            push_cmd(CMD_LINE, cx + w, cy + base_neg, 0, 0, 1'b0);
        end
        push_cmd(CMD_LINE, cx + w, cy - h + r, 0, 0, 1'b0);
        push_cmd(CMD_QUAD, cx + w - r, cy - h, cx + w, cy - h, 1'b0);
        if (side == EDGE_BOTTOM) begin
            push_cmd(CMD_LINE, cx + base_pos, cy - h, 0, 0, 1'b0);
            push_cmd(CMD_LINE, tx, ty, 0, 0, 1'b0);
            push_cmd(CMD_LINE, cx + base_neg, cy - h, 0, 0, 1'b0);
        end
        push_cmd(CMD_LINE, cx - w + r, cy - h, 0, 0, 1'b0);
        push_cmd(CMD_QUAD, cx - w, cy - h + r, cx - w, cy - h, 1'b0);
        if (side == EDGE_LEFT) begin
            push_cmd(CMD_LINE, cx - w, cy + base_neg, 0, 0, 1'b0);
            push_cmd(CMD_LINE, tx, ty, 0, 0, 1'b0);
            push_cmd(CMD_LINE, cx - w, cy + base_pos, 0, 0, 1'b0);
        end
        push_cmd(CMD_LINE, cx - w, cy + h - r, 0, 0, 1'b0);
        push_cmd(CMD_QUAD, cx - w + r, cy + h, cx - w, cy + h, 1'b0);
        push_cmd(CMD_CLOSE, 0, 0, 0, 0, 1'b1);
    endfunction

    task automatic check_field(input string field, input logic [FW-1:0] want,
                               input logic [FW-1:0] got);
        if (got !== want) begin
            o_mismatches++;
            $display("%0t: %s expected %h got %h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                predict_outline(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_path.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: command transaction expected none got %h", $time,
                             i_out_data);
                end else begin
                    head_cmd = expected_path.pop_front();
                    check_field("command", FW'(head_cmd.command), FW'(i_out_data.command));
                    check_field("end_x", head_cmd.end_x, i_out_data.end_x);
                    check_field("end_y", head_cmd.end_y, i_out_data.end_y);
                    check_field("ctrl_x", head_cmd.ctrl_x, i_out_data.ctrl_x);
                    check_field("ctrl_y", head_cmd.ctrl_y, i_out_data.ctrl_y);
                    check_field("last", FW'(head_cmd.last), FW'(i_out_data.last));
                end
            end
        end
        o_pending = expected_path.size();
    end

endmodule

/* tb/callout_outline_path_generator_tb.sv */
// Testbench top: clock, reset, callout stimulus, receiver stalls and the final verdict.
`timescale 1ns / 100ps

module callout_outline_path_generator_tb;
    import copg_pkg::*;

    localparam int NUM_RANDOM   = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_data;
    logic        o_valid;
    logic        i_ready;
    t_out_item   o_data;
    int          mismatch_count;
    int          outstanding;
    int unsigned cycle_count = 0;
    t_in_item    directed_set[$];

    callout_outline_path_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    callout_path_checker path_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .o_mismatches (mismatch_count),
        .o_pending    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic t_in_item callout(input int cx, input int cy, input int wd,
                                         input int ht, input int rad, input int pw,
                                         input int tx, input int ty);
        t_in_item it;
        it.center_x    = cx[FW-1:0];
        it.center_y    = cy[FW-1:0];
        it.rect_width  = wd[SZW-1:0];
        it.rect_height = ht[SZW-1:0];
        it.radius_req  = rad[SZW-1:0];
        it.ptr_base_w  = pw[SZW-1:0];
        it.target_x    = tx[FW-1:0];
        it.target_y    = ty[FW-1:0];
        return it;
    endfunction

    function automatic void add_directed(input t_in_item it);
        directed_set.insert(directed_set.size(), it);
    endfunction

    function automatic logic [FW-1:0] rand_coord();
        int v;
        if ($urandom_range(0, 3) == 0) return FW'($urandom());
        v = int'($urandom_range(0, 1 << 19)) - (1 << 18);
        return v[FW-1:0];
    endfunction

    function automatic logic [SZW-1:0] rand_size();
        case ($urandom_range(0, 3))
            0:       return SZW'($urandom_range(0, 64));
            3:       return SZW'($urandom());
            default: return SZW'($urandom_range(0, 1 << 17));
        endcase
    endfunction

    function automatic longint rand_along(input longint lim);
        return longint'($urandom_range(0, 32'(2 * lim))) - lim;
    endfunction

    // most tips land near an edge of the rectangle so every edge and clamp gets exercised
    function automatic t_in_item random_callout();
        t_in_item it;
        longint   cx, cy, hw, hh, tx, ty, jit;
        it.center_x    = rand_coord();
        it.center_y    = rand_coord();
        it.rect_width  = rand_size();
        it.rect_height = rand_size();
        it.ptr_base_w  = rand_size();
        case ($urandom_range(0, 3))
            0: it.radius_req = '0;
            1: it.radius_req = SZW'($urandom_range(0, 255));
            2: it.radius_req = SZW'($urandom());
            default: it.radius_req = ((it.rect_width < it.rect_height) ?
                                      it.rect_width : it.rect_height) >> 1;
        endcase
        if ($urandom_range(0, 9) < 7) begin
            cx  = $signed(it.center_x);
            cy  = $signed(it.center_y);
            hw  = it.rect_width >> 1;
            hh  = it.rect_height >> 1;
            jit = longint'($urandom_range(0, 512)) - 256;
            case ($urandom_range(0, 3))
                0: begin
                    tx = cx + rand_along(hw);
                    ty = cy - hh + jit;
                end
                1: begin
                    tx = cx + rand_along(hw);
                    ty = cy + hh + jit;
                end
                2: begin
                    tx = cx - hw + jit;
                    ty = cy + rand_along(hh);
                end
                default: begin
                    tx = cx + hw + jit;
                    ty = cy + rand_along(hh);
                end
            endcase
            it.target_x = tx[FW-1:0];
            it.target_y = ty[FW-1:0];
        end else begin
            it.target_x = rand_coord();
            it.target_y = rand_coord();
        end
        return it;
    endfunction

    task automatic send_callout(input t_in_item it);
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic drain_pause();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    // receiver: segments of always-ready, random, mostly-ready and heavy stalling, plus two long hold-offs
    initial begin
        int seg;
        int mode;
        int len;
        seg = 0;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            seg++;
            if (seg == 6 || seg == 45) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_ready <= 1'b0;
                end
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(4, 60);
                repeat (len) begin
                    @(negedge i_clk);
                    case (mode)
                        0: i_ready <= 1'b1;
                        1: i_ready <= $urandom_range(0, 1);
                        2: i_ready <= ($urandom_range(0, 3) == 0);
                        default: i_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    initial begin
        int burst_left;
        burst_left = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;

        add_directed(callout(0, 0, 0, 0, 0, 0, 0, 0));
        add_directed(callout(8388607, 8388607, 'h7FFFFF, 'h7FFFFF, 'h7FFFFF,
                             'h7FFFFF, -8388608, -8388608));
        add_directed(callout(-8388608, -8388608, 'h7FFFFF, 'h7FFFFF, 'h7FFFFF,
                             'h7FFFFF, 8388607, 8388607));
        // one tip near each edge
        add_directed(callout(0, 0, 'h2000, 'h2000, 'h400, 'h800, 'h100, -'h1200));
        add_directed(callout(0, 0, 'h2000, 'h2000, 'h400, 'h800, 'h100, 'h1200));
        add_directed(callout(0, 0, 'h2000, 'h2000, 'h400, 'h800, -'h1200, 'h80));
        add_directed(callout(0, 0, 'h2000, 'h2000, 'h400, 'h800, 'h1200, -'h80));
        // ties: bottom/top, top/left corner, left/right, right/bottom corner
        add_directed(callout('h1234, -'h4321, 'h10000, 'h4000, 'h300, 'h600,
                             'h1234, -'h4321));
        add_directed(callout(0, 0, 'h2000, 'h2000, 'h200, 'h400, -'h1000, 'h1000));
        add_directed(callout(0, 0, 'h2000, 'h8000, 'h100, 'h200, 0, 0));
        add_directed(callout(0, 0, 'h2000, 'h2000, 'h200, 'h400, 'h1000, -'h1000));
        // zero radius, radius above both half-sizes
        add_directed(callout('h500, 'h500, 'h3000, 'h3000, 0, 'h400, 'h1E00, 'h500));
        add_directed(callout(0, 0, 'h1000, 'h3000, 'h7FFFFF, 'h200, 0, -'h2000));
        add_directed(callout(0, 0, 'h3000, 'h1000, 'h7FFFFF, 'h200, 0, 'h1000));
        // odd sizes and odd pointer width lose the low bit
        add_directed(callout('h101, -'h101, 'h2001, 'h1FFF, 'h1FF, 'h3, 'h101, 'h1000));
        add_directed(callout(-'h5000, 'h7000, 'h6000, 'h2000, 'h800, 'h801,
                             -'h5000, 'h8100));
        // pointer base clamped at both ends, zero pointer, tip far outside
        add_directed(callout(0, 0, 'h4000, 'h2000, 'h100, 'h7FFFFF, 'h300, 'h1400));
        add_directed(callout(0, 0, 'h4000, 'h4000, 'h100, 0, -'h2100, 'h40));
        add_directed(callout(0, 0, 'h2000, 'h2000, 'h100, 'h1000, 'h3000, -'h9000));
        // corner sums past the coordinate range
        add_directed(callout('h7FF000, 0, 'h4000, 'h2000, 'h100, 'h400, 'h7FFFFF, 0));
        add_directed(callout(-'h7FF000, -'h7FF000, 'h4000, 'h4000, 'h100, 'h400,
                             -'h7FFFFF, -'h7FF000));

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_set[k]) begin
            send_callout(directed_set[k]);
            idle_gap($urandom_range(0, 2));
        end
        drain_pause();

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM / 2) drain_pause();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 24));
            end
            send_callout(random_callout());
            burst_left--;
        end
        i_valid <= 1'b0;

        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* callout_outline_path_generator.f */
design/copg_pkg.sv
design/callout_outline_path_generator.sv
tb/callout_path_checker.sv
tb/callout_outline_path_generator_tb.sv
